/* src/rk3_pkg.sv */
// Shared constants, codes and saturating fixed-point helpers of the RK3 step core.
package rk3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int STEP_W     = 17;
  localparam int INDEX_W    = 8;
  localparam int STATUS_W   = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 17'd6554;

  // Common denominator of the Ralston weights 2/9, 3/9 and 4/9.
  localparam int WEIGHT_DIV_W = 5;
  localparam logic signed [WEIGHT_DIV_W-1:0] WEIGHT_DIV = 5'sd9;

  // Working width of all intermediate sums and products before saturation.
  localparam int WIDE_W = 136;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  function automatic logic signed [WIDE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x,
                                                      input int dw);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed((WIDE_W'(1) << (dw - 1)) - WIDE_W'(1));
    lo = ~hi;
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  function automatic logic sat_hit(input logic signed [WIDE_W-1:0] x, input int dw);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed((WIDE_W'(1) << (dw - 1)) - WIDE_W'(1));
    lo = ~hi;
    return (x > hi) || (x < lo);
  endfunction

  // Arithmetic right shift that rounds toward zero, like a signed division by 2^sh.
  function automatic logic signed [WIDE_W-1:0] trunc_shift(input logic signed [WIDE_W-1:0] x,
                                                          input int sh);
    logic signed [WIDE_W-1:0] bias;
    bias = x[WIDE_W-1] ? $signed((WIDE_W'(1) << sh) - WIDE_W'(1)) : '0;
    return (x + bias) >>> sh;
  endfunction

endpackage

/* src/rk3_in_if.sv */
// Input channel of the RK3 step core: state of one trajectory per beat.
interface rk3_in_if #(
  parameter int DW = rk3_pkg::DATA_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [DW-1:0]           time_now;
  logic signed [DW-1:0]           value_now;
  logic signed [DW-1:0]           slope_now;
  logic [rk3_pkg::INDEX_W-1:0]    step_index;

  modport source (output valid, time_now, value_now, slope_now, step_index, input ready);
  modport sink   (input valid, time_now, value_now, slope_now, step_index, output ready);
endinterface

/* src/rk3_out_if.sv */
// Output channel of the RK3 step core: advanced state of one trajectory per beat.
interface rk3_out_if #(
  parameter int DW = rk3_pkg::DATA_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [DW-1:0]           value_next;
  logic signed [DW-1:0]           slope_next;
  logic [rk3_pkg::INDEX_W-1:0]    index_out;
  logic [rk3_pkg::STATUS_W-1:0]   status;

  modport source (output valid, value_next, slope_next, index_out, status, input ready);
  modport sink   (input valid, value_next, slope_next, index_out, status, output ready);
endinterface

/* src/rk3_div.sv */
// Pipelined restoring divider on magnitudes, one quotient bit per stage, with sideband.
module rk3_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [NUM_W-1:0]        mag_o,
  output logic                    neg_o,
  output logic [SIDE_W-1:0]       side_o
);

  logic              vld_q  [NUM_W+1];
  logic [NUM_W-1:0]  n_q    [NUM_W+1];
  logic              neg_q  [NUM_W+1];
  logic [SIDE_W-1:0] side_q [NUM_W+1];
  logic [DEN_W-1:0]  r_q    [NUM_W];
  logic [DEN_W-1:0]  d_q    [NUM_W];

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;

  assign num_mag = num_i[NUM_W-1] ? $unsigned(~num_i + 1'b1) : $unsigned(num_i);
  assign den_mag = den_i[DEN_W-1] ? $unsigned(~den_i + 1'b1) : $unsigned(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= num_mag;
      r_q[0]    <= '0;
      d_q[0]    <= den_mag;
      neg_q[0]  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= NUM_W; s++) begin : g_stage
    logic [DEN_W:0] rs;
    logic [DEN_W:0] diff;
    logic           ge;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign rs   = {r_q[s-1], n_q[s-1][NUM_W-1]};
    assign diff = rs - {1'b0, d_q[s-1]};
    assign ge   = rs >= {1'b0, d_q[s-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]    <= {n_q[s-1][NUM_W-2:0], ge};
        neg_q[s]  <= neg_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end

    if (s < NUM_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[s] <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
          d_q[s] <= d_q[s-1];
        end
      end
    end
  end

  assign vld_o  = vld_q[NUM_W];
  assign mag_o  = n_q[NUM_W];
  assign neg_o  = neg_q[NUM_W];
  assign side_o = side_q[NUM_W];

endmodule

/* src/rk3_eval.sv */
// One derivative evaluation: k0 = h*a1 and k1 = h*((t+1)a1 + 2(t-1)a0)/t, pipelined.
module rk3_eval #(
  parameter int DATA_WIDTH = rk3_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rk3_pkg::FRAC_BITS,
  parameter int SIDE_W     = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [rk3_pkg::STEP_W-1:0]   h_i,
  input  logic                         vld_i,
  input  logic signed [DATA_WIDTH-1:0] tn_i,
  input  logic signed [DATA_WIDTH-1:0] a0_i,
  input  logic signed [DATA_WIDTH-1:0] a1_i,
  input  logic                         sat_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic signed [DATA_WIDTH-1:0] k0_o,
  output logic signed [DATA_WIDTH-1:0] k1_o,
  output logic                         sat_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int XW = rk3_pkg::WIDE_W;
  localparam int HW = rk3_pkg::STEP_W + 1;
  localparam int DSIDE_W = SIDE_W + W + 1;
  localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< F;

  logic signed [HW-1:0] hs;
  assign hs = $signed({1'b0, h_i});

  // Stage 1: t+1 and t-1.
  logic                 v1_q, s1_q;
  logic signed [W-1:0]  tp1_q, tm1_q, tn1_q, a01_q, a11_q;
  logic [SIDE_W-1:0]    side1_q;
  logic signed [XW-1:0] tp_x, tm_x;

  assign tp_x = XW'(tn_i) + ONE_X;
  assign tm_x = XW'(tn_i) - ONE_X;

  // Stage 2: raw products.
  logic                      v2_q, s2_q;
  logic signed [2*W-1:0]     pa2_q, pb2_q;
  logic signed [W+HW-1:0]    pk2_q;
  logic signed [W-1:0]       tn2_q;
  logic [SIDE_W-1:0]         side2_q;

  // Stage 3: scaled products, doubled second term.
  logic                 v3_q, s3_q;
  logic signed [W-1:0]  a3_q, b3_q, k03_q, tn3_q;
  logic [SIDE_W-1:0]    side3_q;
  logic signed [XW-1:0] fa_x, fb_x, fk_x, b_x;
  logic signed [W-1:0]  fb_w;

  assign fa_x = rk3_pkg::trunc_shift(XW'(pa2_q), F);
  assign fb_x = rk3_pkg::trunc_shift(XW'(pb2_q), F);
  assign fk_x = rk3_pkg::trunc_shift(XW'(pk2_q), F);
  assign fb_w = W'(rk3_pkg::sat_val(fb_x, W));
  assign b_x  = XW'(fb_w) + XW'(fb_w);

  // Stage 4: numerator.
  logic                 v4_q, s4_q;
  logic signed [W-1:0]  num4_q, k04_q, tn4_q;
  logic [SIDE_W-1:0]    side4_q;
  logic signed [XW-1:0] num_x;

  assign num_x = XW'(a3_q) + XW'(b3_q);

  // Divider: (num << F) / t.
  logic               dv_vld, dv_neg;
  logic [W+F-1:0]     dv_mag;
  logic [DSIDE_W-1:0] dv_side;
  logic signed [W-1:0] dv_k0;
  logic               dv_s;
  logic [SIDE_W-1:0]  dv_rest;

  rk3_div #(
    .NUM_W  (W + F),
    .DEN_W  (W),
    .SIDE_W (DSIDE_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (v4_q),
    .num_i  ($signed({num4_q, {F{1'b0}}})),
    .den_i  (tn4_q),
    .side_i ({k04_q, s4_q, side4_q}),
    .vld_o  (dv_vld),
    .mag_o  (dv_mag),
    .neg_o  (dv_neg),
    .side_o (dv_side)
  );

  assign {dv_k0, dv_s, dv_rest} = dv_side;

  // Stage 5: signed quotient, saturated.
  logic                 v5_q, s5_q;
  logic signed [W-1:0]  acc5_q, k05_q;
  logic [SIDE_W-1:0]    side5_q;
  logic signed [XW-1:0] q_abs, q_x;

  assign q_abs = XW'($signed({1'b0, dv_mag}));
  assign q_x   = dv_neg ? -q_abs : q_abs;

  // Stage 6: h times the acceleration.
  logic                   v6_q, s6_q;
  logic signed [W+HW-1:0] pk6_q;
  logic signed [W-1:0]    k06_q;
  logic [SIDE_W-1:0]      side6_q;

  // Stage 7: scaled k1.
  logic                 v7_q, s7_q;
  logic signed [W-1:0]  k07_q, k17_q;
  logic [SIDE_W-1:0]    side7_q;
  logic signed [XW-1:0] k1_x;

  assign k1_x = rk3_pkg::trunc_shift(XW'(pk6_q), F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= dv_vld;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tp1_q   <= W'(rk3_pkg::sat_val(tp_x, W));
      tm1_q   <= W'(rk3_pkg::sat_val(tm_x, W));
      s1_q    <= sat_i | rk3_pkg::sat_hit(tp_x, W) | rk3_pkg::sat_hit(tm_x, W);
      tn1_q   <= tn_i;
      a01_q   <= a0_i;
      a11_q   <= a1_i;
      side1_q <= side_i;

      pa2_q   <= tp1_q * a11_q;
      pb2_q   <= tm1_q * a01_q;
      pk2_q   <= a11_q * hs;
      tn2_q   <= tn1_q;
      s2_q    <= s1_q;
      side2_q <= side1_q;

      a3_q    <= W'(rk3_pkg::sat_val(fa_x, W));
      b3_q    <= W'(rk3_pkg::sat_val(b_x, W));
      k03_q   <= W'(rk3_pkg::sat_val(fk_x, W));
      s3_q    <= s2_q | rk3_pkg::sat_hit(fa_x, W) | rk3_pkg::sat_hit(fb_x, W)
                 | rk3_pkg::sat_hit(b_x, W) | rk3_pkg::sat_hit(fk_x, W);
      tn3_q   <= tn2_q;
      side3_q <= side2_q;

      num4_q  <= W'(rk3_pkg::sat_val(num_x, W));
      s4_q    <= s3_q | rk3_pkg::sat_hit(num_x, W);
      k04_q   <= k03_q;
      tn4_q   <= tn3_q;
      side4_q <= side3_q;

      acc5_q  <= W'(rk3_pkg::sat_val(q_x, W));
      s5_q    <= dv_s | rk3_pkg::sat_hit(q_x, W);
      k05_q   <= dv_k0;
      side5_q <= dv_rest;

      pk6_q   <= acc5_q * hs;
      k06_q   <= k05_q;
      s6_q    <= s5_q;
      side6_q <= side5_q;

      k17_q   <= W'(rk3_pkg::sat_val(k1_x, W));
      s7_q    <= s6_q | rk3_pkg::sat_hit(k1_x, W);
      k07_q   <= k06_q;
      side7_q <= side6_q;
    end
  end

  assign vld_o  = v7_q;
  assign k0_o   = k07_q;
  assign k1_o   = k17_q;
  assign sat_o  = s7_q;
  assign side_o = side7_q;

endmodule

/* src/ralston_rk3_ode_step_core.sv */
// Top level of the Ralston third-order Runge-Kutta step core.
//
// Each input beat carries t, y and dy of one trajectory in signed fixed point plus a slot
// index; each output beat carries y and dy one step h later, the same index and a status
// (ok, zero time at a node, or saturation). Beats are independent, so interleaved
// trajectories stream at one beat per clock while the output is not stalled. h is written
// through cfg_we_i/cfg_wdata_i and must only change while no beat is in flight; reset sets
// it to about 0.1. The pipeline holds the three derivative evaluations, each with a
// one-bit-per-stage divider of DATA_WIDTH+FRAC_BITS stages, and the final divide by nine,
// which is a five-stage shift-and-add estimate with a remainder fix.
// The whole pipeline advances together whenever the output register is empty or being
// taken; when the receiver stalls, every stage holds and in_i.ready drops in the same
// cycle, so nothing is lost or repeated. Reset clears all valid bits.
module ralston_rk3_ode_step_core #(
  parameter int DATA_WIDTH = rk3_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rk3_pkg::FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rk3_pkg::STEP_W-1:0] cfg_wdata_i,
  rk3_in_if.sink                     in_i,
  rk3_out_if.source                  out_o
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = rk3_pkg::WIDE_W;
  localparam int IW = rk3_pkg::INDEX_W;
  localparam int SW = W + 4;
  localparam int RW = SW + 5;
  localparam int DIV9_LAT = 5;

  typedef struct packed {
    logic signed [W-1:0] y0;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] tm;
    logic signed [W-1:0] tq;
    logic [IW-1:0]       idx;
    logic                zero;
  } ctx1_t;

  typedef struct packed {
    logic signed [W-1:0] y0;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] tq;
    logic [IW-1:0]       idx;
    logic                zero;
    logic signed [W-1:0] k10;
    logic signed [W-1:0] k11;
  } ctx2_t;

  typedef struct packed {
    logic signed [W-1:0] y0;
    logic signed [W-1:0] y1;
    logic [IW-1:0]       idx;
    logic                zero;
    logic signed [W-1:0] k10;
    logic signed [W-1:0] k11;
    logic signed [W-1:0] k20;
    logic signed [W-1:0] k21;
  } ctx3_t;

  typedef struct packed {
    logic signed [W-1:0] y0;
    logic [IW-1:0]       idx;
    logic                zero;
    logic                sat;
  } ctx4_t;

  logic en;
  logic [rk3_pkg::STEP_W-1:0] h_q;
  logic out_v_q;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= rk3_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      h_q <= cfg_wdata_i;
    end
  end

  // Stage T1: node times t+h/2 and t+3h/4 and the zero-time check.
  logic signed [XW-1:0] t_x, h_x, tm_x, tq_x;
  logic signed [W-1:0]  tm_w, tq_w;
  logic                 v1_q, s1_q;
  logic signed [W-1:0]  t1_q;
  ctx1_t                c1_q;

  assign t_x  = XW'(in_i.time_now);
  assign h_x  = XW'($signed({1'b0, h_q}));
  assign tm_x = t_x + (h_x >>> 1);
  assign tq_x = t_x + ((h_x + h_x + h_x) >>> 2);
  assign tm_w = W'(rk3_pkg::sat_val(tm_x, W));
  assign tq_w = W'(rk3_pkg::sat_val(tq_x, W));

  // First evaluation at (t, y, dy).
  logic                         e1_v, e1_s;
  logic signed [W-1:0]          e1_k0, e1_k1;
  logic [$bits(ctx1_t)-1:0]     e1_side;
  ctx1_t                        c1_o;

  rk3_eval #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     ($bits(ctx1_t))
  ) u_eval1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (h_q),
    .vld_i  (v1_q),
    .tn_i   (t1_q),
    .a0_i   (c1_q.y0),
    .a1_i   (c1_q.y1),
    .sat_i  (s1_q),
    .side_i (c1_q),
    .vld_o  (e1_v),
    .k0_o   (e1_k0),
    .k1_o   (e1_k1),
    .sat_o  (e1_s),
    .side_o (e1_side)
  );

  assign c1_o = ctx1_t'(e1_side);

  // Stage T2: midpoint state y + k1/2.
  logic signed [XW-1:0] m0_x, m1_x;
  logic                 v2_q, s2_q;
  logic signed [W-1:0]  t2_q, a02_q, a12_q;
  ctx2_t                c2_q;

  assign m0_x = XW'(c1_o.y0) + rk3_pkg::trunc_shift(XW'(e1_k0), 1);
  assign m1_x = XW'(c1_o.y1) + rk3_pkg::trunc_shift(XW'(e1_k1), 1);

  logic                         e2_v, e2_s;
  logic signed [W-1:0]          e2_k0, e2_k1;
  logic [$bits(ctx2_t)-1:0]     e2_side;
  ctx2_t                        c2_o;

  rk3_eval #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     ($bits(ctx2_t))
  ) u_eval2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (h_q),
    .vld_i  (v2_q),
    .tn_i   (t2_q),
    .a0_i   (a02_q),
    .a1_i   (a12_q),
    .sat_i  (s2_q),
    .side_i (c2_q),
    .vld_o  (e2_v),
    .k0_o   (e2_k0),
    .k1_o   (e2_k1),
    .sat_o  (e2_s),
    .side_o (e2_side)
  );

  assign c2_o = ctx2_t'(e2_side);

  // Stage T3: three-quarter state y + 3*k2/4.
  logic signed [XW-1:0] q0_x, q1_x;
  logic                 v3_q, s3_q;
  logic signed [W-1:0]  t3_q, a03_q, a13_q;
  ctx3_t                c3_q;

  assign q0_x = XW'(c2_o.y0)
                + rk3_pkg::trunc_shift(XW'(e2_k0) + XW'(e2_k0) + XW'(e2_k0), 2);
  assign q1_x = XW'(c2_o.y1)
                + rk3_pkg::trunc_shift(XW'(e2_k1) + XW'(e2_k1) + XW'(e2_k1), 2);

  logic                         e3_v, e3_s;
  logic signed [W-1:0]          e3_k0, e3_k1;
  logic [$bits(ctx3_t)-1:0]     e3_side;
  ctx3_t                        c3_o;

  rk3_eval #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     ($bits(ctx3_t))
  ) u_eval3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .h_i    (h_q),
    .vld_i  (v3_q),
    .tn_i   (t3_q),
    .a0_i   (a03_q),
    .a1_i   (a13_q),
    .sat_i  (s3_q),
    .side_i (c3_q),
    .vld_o  (e3_v),
    .k0_o   (e3_k0),
    .k1_o   (e3_k1),
    .sat_o  (e3_s),
    .side_o (e3_side)
  );

  assign c3_o = ctx3_t'(e3_side);

  // Stage T4: weighted sums 2*k1 + 3*k2 + 4*k3, divided by nine below.
  logic signed [XW-1:0] w0_x, w1_x;
  logic                 v4_q;
  logic signed [SW-1:0] w04_q, w14_q;
  ctx4_t                c4_q;
  logic signed [W-1:0]  y14_q;

  assign w0_x = (XW'(c3_o.k10) <<< 1) + XW'(c3_o.k20) + XW'(c3_o.k20) + XW'(c3_o.k20)
                + (XW'(e3_k0) <<< 2);
  assign w1_x = (XW'(c3_o.k11) <<< 1) + XW'(c3_o.k21) + XW'(c3_o.k21) + XW'(c3_o.k21)
                + (XW'(e3_k1) <<< 2);

  // Divide by nine on magnitudes: 8/9 is 7/8 times (1+2^-6)(1+2^-12)(1+2^-24)(1+2^-48),
  // and the remainder check then moves the estimate by one in either direction.
  logic signed [SW-1:0] wsum4 [2];
  logic signed [SW-1:0] quo5  [2];
  logic [DIV9_LAT-1:0]  dv_q;
  ctx4_t                cd_q [DIV9_LAT];
  logic signed [W-1:0]  yd_q [DIV9_LAT];
  ctx4_t                c4_o;

  assign wsum4[0] = w04_q;
  assign wsum4[1] = w14_q;

  for (genvar l = 0; l < 2; l++) begin : g_div9
    logic [SW-1:0]        mag_d, p2_x, p2_d, p3_x, p3_y, p3_z, p3_d, fix_d;
    logic [SW-1:0]        mag1_q, mag2_q, mag3_q, p2_q, p3_q, quo4_q;
    logic                 neg1_q, neg2_q, neg3_q, neg4_q;
    logic signed [RW-1:0] rem4_d, rem4_q;
    logic signed [SW-1:0] quo5_q;

    assign mag_d  = wsum4[l][SW-1] ? $unsigned(-wsum4[l]) : $unsigned(wsum4[l]);
    assign p2_x   = mag1_q - (mag1_q >> 3);
    assign p2_d   = p2_x + (p2_x >> 6);
    assign p3_x   = p2_q + (p2_q >> 12);
    assign p3_y   = p3_x + (p3_x >> 24);
    assign p3_z   = p3_y + (p3_y >> 48);
    assign p3_d   = p3_z >> 3;
    assign rem4_d = $signed({5'b0, mag3_q}) - $signed({5'b0, p3_q})
                    - ($signed({5'b0, p3_q}) <<< 3);

    always_comb begin
      if (rem4_q >= RW'(rk3_pkg::WEIGHT_DIV)) begin
        fix_d = quo4_q + 1'b1;
      end else if (rem4_q < 0) begin
        fix_d = quo4_q - 1'b1;
      end else begin
        fix_d = quo4_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag1_q <= mag_d;
        neg1_q <= wsum4[l][SW-1];
        p2_q   <= p2_d;
        mag2_q <= mag1_q;
        neg2_q <= neg1_q;
        p3_q   <= p3_d;
        mag3_q <= mag2_q;
        neg3_q <= neg2_q;
        rem4_q <= rem4_d;
        quo4_q <= p3_q;
        neg4_q <= neg3_q;
        quo5_q <= neg4_q ? -$signed(fix_d) : $signed(fix_d);
      end
    end

    assign quo5[l] = quo5_q;
  end

  assign c4_o = cd_q[DIV9_LAT-1];

  // Stage T5: final sums, status and the output register.
  logic signed [XW-1:0] n0_x, n1_x;
  logic                 sat_any;
  rk3_pkg::status_e     status_d;
  logic signed [W-1:0]  value_d, slope_d;
  logic signed [W-1:0]  value_q, slope_q;
  logic [IW-1:0]        index_q;
  rk3_pkg::status_e     status_q;

  assign n0_x    = XW'(c4_o.y0) + XW'(quo5[0]);
  assign n1_x    = XW'(yd_q[DIV9_LAT-1]) + XW'(quo5[1]);
  assign sat_any = c4_o.sat | rk3_pkg::sat_hit(n0_x, W) | rk3_pkg::sat_hit(n1_x, W);

  always_comb begin
    if (c4_o.zero) begin
      // A zero node time returns the input state untouched.
      value_d  = c4_o.y0;
      slope_d  = yd_q[DIV9_LAT-1];
      status_d = rk3_pkg::ST_DIV_ZERO;
    end else begin
      value_d  = W'(rk3_pkg::sat_val(n0_x, W));
      slope_d  = W'(rk3_pkg::sat_val(n1_x, W));
      status_d = sat_any ? rk3_pkg::ST_SATURATED : rk3_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_i.valid;
      v2_q    <= e1_v;
      v3_q    <= e2_v;
      v4_q    <= e3_v;
      dv_q    <= {dv_q[DIV9_LAT-2:0], v4_q};
      out_v_q <= dv_q[DIV9_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q      <= in_i.time_now;
      c1_q.y0   <= in_i.value_now;
      c1_q.y1   <= in_i.slope_now;
      c1_q.tm   <= tm_w;
      c1_q.tq   <= tq_w;
      c1_q.idx  <= in_i.step_index;
      c1_q.zero <= (in_i.time_now == '0) || (tm_w == '0) || (tq_w == '0);
      s1_q      <= rk3_pkg::sat_hit(tm_x, W) | rk3_pkg::sat_hit(tq_x, W);

      t2_q      <= c1_o.tm;
      a02_q     <= W'(rk3_pkg::sat_val(m0_x, W));
      a12_q     <= W'(rk3_pkg::sat_val(m1_x, W));
      s2_q      <= e1_s | rk3_pkg::sat_hit(m0_x, W) | rk3_pkg::sat_hit(m1_x, W);
      c2_q.y0   <= c1_o.y0;
      c2_q.y1   <= c1_o.y1;
      c2_q.tq   <= c1_o.tq;
      c2_q.idx  <= c1_o.idx;
      c2_q.zero <= c1_o.zero;
      c2_q.k10  <= e1_k0;
      c2_q.k11  <= e1_k1;

      t3_q      <= c2_o.tq;
      a03_q     <= W'(rk3_pkg::sat_val(q0_x, W));
      a13_q     <= W'(rk3_pkg::sat_val(q1_x, W));
      s3_q      <= e2_s | rk3_pkg::sat_hit(q0_x, W) | rk3_pkg::sat_hit(q1_x, W);
      c3_q.y0   <= c2_o.y0;
      c3_q.y1   <= c2_o.y1;
      c3_q.idx  <= c2_o.idx;
      c3_q.zero <= c2_o.zero;
      c3_q.k10  <= c2_o.k10;
      c3_q.k11  <= c2_o.k11;
      c3_q.k20  <= e2_k0;
      c3_q.k21  <= e2_k1;

      w04_q     <= SW'(w0_x);
      w14_q     <= SW'(w1_x);
      c4_q.y0   <= c3_o.y0;
      c4_q.idx  <= c3_o.idx;
      c4_q.zero <= c3_o.zero;
      c4_q.sat  <= e3_s;
      y14_q     <= c3_o.y1;

      cd_q[0]   <= c4_q;
      yd_q[0]   <= y14_q;
      for (int i = 1; i < DIV9_LAT; i++) begin
        cd_q[i] <= cd_q[i-1];
        yd_q[i] <= yd_q[i-1];
      end

      value_q   <= value_d;
      slope_q   <= slope_d;
      index_q   <= c4_o.idx;
      status_q  <= status_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.value_next = value_q;
  assign out_o.slope_next = slope_q;
  assign out_o.index_out  = index_q;
  assign out_o.status     = status_q;

endmodule
